/* hdl/ggcg_pkg.sv */
package ggcg_pkg;

	// Number format: signed fixed point, FRAC_BITS fractional bits
	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int ACC_W       = 64;

	// Face product and its shifted magnitude
	localparam int PROD_W = 2 * VALUE_WIDTH;
	localparam int SHP_W  = PROD_W - FRAC_BITS;
	localparam int EXT_W  = ((SHP_W > ACC_W) ? SHP_W : ACC_W) + 1;

	// Divider: numerator is |sum| shifted up by FRAC_BITS, one bit per cycle
	localparam int NUM_W = ACC_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W);

	// Cell queue between accumulator and divider
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Result status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_MEAS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT       = 2'd2;

	// One finished cell handed from the front to the divider
	typedef struct packed {
		logic signed [ACC_W-1:0]    sum_x;
		logic signed [ACC_W-1:0]    sum_y;
		logic                       acc_sat;
		logic [VALUE_WIDTH-1:0]     meas;
	} cell_acc_t;

endpackage

/* hdl/ggcg_front.sv */
module ggcg_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] face_value,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] area_x,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] area_y,
	input  logic                                  is_owner,
	input  logic [ggcg_pkg::VALUE_WIDTH-1:0]      cell_measure,
	input  logic                                  last_face,
	output logic                                  push,
	output ggcg_pkg::cell_acc_t                   push_data,
	input  logic                                  q_full
);
	import ggcg_pkg::*;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Magnitude of a signed field as an unsigned value of the same width
	function automatic logic [VALUE_WIDTH-1:0] mag_v(input logic [VALUE_WIDTH-1:0] v);
		return v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// Shift product down, clamp to the signed accumulator range, apply sign.
	// Returns {sat, term}.
	function automatic logic [ACC_W:0] face_term(input logic [PROD_W-1:0] prod,
			input logic neg);
		logic [EXT_W-1:0] psh;
		logic [EXT_W-1:0] lim;
		logic [EXT_W-1:0] m;
		logic             sat;
		psh = EXT_W'(prod[PROD_W-1:FRAC_BITS]);
		lim = EXT_W'(ACC_MAX) + EXT_W'(neg);
		sat = psh > lim;
		m   = sat ? lim : psh;
		return {sat, neg ? (~m[ACC_W-1:0] + 1'b1) : m[ACC_W-1:0]};
	endfunction

	// Saturating signed add. Returns {overflow, sum}.
	function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] r;
		logic             ovf;
		r   = a + b;
		ovf = (a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]);
		return {ovf, ovf ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : r};
	endfunction

	logic                   en;
	logic                   v_s1, v_s2;
	logic [PROD_W-1:0]      prod_x_s1, prod_y_s1;
	logic                   neg_x_s1, neg_y_s1, last_s1;
	logic [VALUE_WIDTH-1:0] meas_s1, meas_s2;
	logic [ACC_W-1:0]       term_x_s2, term_y_s2;
	logic                   tsat_s2, last_s2;
	logic [ACC_W:0]         tx, ty, ax, ay;
	logic [ACC_W-1:0]       sum_x_q, sum_y_q;
	logic                   acc_sat_q, acc_sat_n;

	// Whole pipeline holds while a finished cell waits for queue space
	assign en       = !(v_s2 && last_s2 && q_full);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: magnitudes and products; stage 2: clamped signed terms
	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= PROD_W'(mag_v(face_value)) * PROD_W'(mag_v(area_x));
			prod_y_s1 <= PROD_W'(mag_v(face_value)) * PROD_W'(mag_v(area_y));
			neg_x_s1  <= face_value[VALUE_WIDTH-1] ^ area_x[VALUE_WIDTH-1] ^ !is_owner;
			neg_y_s1  <= face_value[VALUE_WIDTH-1] ^ area_y[VALUE_WIDTH-1] ^ !is_owner;
			last_s1   <= last_face;
			meas_s1   <= cell_measure;
			term_x_s2 <= tx[ACC_W-1:0];
			term_y_s2 <= ty[ACC_W-1:0];
			tsat_s2   <= tx[ACC_W] | ty[ACC_W];
			last_s2   <= last_s1;
			meas_s2   <= meas_s1;
		end
	end

	always_comb begin
		tx        = face_term(prod_x_s1, neg_x_s1);
		ty        = face_term(prod_y_s1, neg_y_s1);
		ax        = sat_add(sum_x_q, term_x_s2);
		ay        = sat_add(sum_y_q, term_y_s2);
		acc_sat_n = acc_sat_q | tsat_s2 | ax[ACC_W] | ay[ACC_W];
	end

	// Accumulator; cleared after each last face
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			acc_sat_q <= 1'b0;
		end else if (en && v_s2) begin
			if (last_s2) begin
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				acc_sat_q <= 1'b0;
			end else begin
				sum_x_q   <= ax[ACC_W-1:0];
				sum_y_q   <= ay[ACC_W-1:0];
				acc_sat_q <= acc_sat_n;
			end
		end
	end

	assign push              = v_s2 && last_s2 && !q_full;
	assign push_data.sum_x   = ax[ACC_W-1:0];
	assign push_data.sum_y   = ay[ACC_W-1:0];
	assign push_data.acc_sat = acc_sat_n;
	assign push_data.meas    = meas_s2;

endmodule

/* hdl/ggcg_queue.sv */
module ggcg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ggcg_pkg::cell_acc_t push_data,
	output logic                full,
	input  logic                pop,
	output ggcg_pkg::cell_acc_t head,
	output logic                empty
);
	import ggcg_pkg::*;

	cell_acc_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap naturally at a power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

/* hdl/ggcg_back.sv */
module ggcg_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	output logic                                  pop,
	input  ggcg_pkg::cell_acc_t                   head,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ggcg_pkg::VALUE_WIDTH-1:0] grad_x,
	output logic signed [ggcg_pkg::VALUE_WIDTH-1:0] grad_y,
	output logic [ggcg_pkg::STATUS_W-1:0]         status
);
	import ggcg_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	function automatic logic [ACC_W-1:0] mag_acc(input logic [ACC_W-1:0] v);
		return v[ACC_W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [1:0]             state_q;
	logic                   axis_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NUM_W-1:0]       num_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH:0]   quo_q;
	logic                   ovf_q, neg_q;
	logic [ACC_W-1:0]       sum_y_q;
	logic [VALUE_WIDTH-1:0] meas_q;
	logic                   acc_sat_q, sat_x_q;
	logic [VALUE_WIDTH-1:0] gx_q, gy_q, res_x_q, res_y_q;
	logic [STATUS_W-1:0]    st_q, res_st_q;
	logic                   out_valid_q;

	logic [VALUE_WIDTH:0]   rem_sh, rem_n, quo_n, lim;
	logic                   ge, ovf_n, ax_sat;
	logic [VALUE_WIDTH:0]   qsel;
	logic [VALUE_WIDTH-1:0] qres;

	// One restoring-division step, plus the saturated signed quotient
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, meas_q};
		rem_n  = ge ? (rem_sh - {1'b0, meas_q}) : rem_sh;
		quo_n  = {quo_q[VALUE_WIDTH-1:0], ge};
		ovf_n  = ovf_q | quo_q[VALUE_WIDTH];
		lim    = ((VALUE_WIDTH+1)'(1) << (VALUE_WIDTH-1)) - (VALUE_WIDTH+1)'(!neg_q);
		ax_sat = ovf_n || (quo_n > lim);
		qsel   = ax_sat ? lim : quo_n;
		qres   = neg_q ? (~qsel[VALUE_WIDTH-1:0] + 1'b1) : qsel[VALUE_WIDTH-1:0];
	end

	assign pop = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
			sum_y_q     <= '0;
			meas_q      <= '0;
			acc_sat_q   <= 1'b0;
			sat_x_q     <= 1'b0;
			gx_q        <= '0;
			gy_q        <= '0;
			st_q        <= ST_OK;
			res_x_q     <= '0;
			res_y_q     <= '0;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// Result register: load from the done state, else drop valid once taken
			if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
				res_x_q     <= gx_q;
				res_y_q     <= gy_q;
				res_st_q    <= st_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						sum_y_q   <= head.sum_y;
						meas_q    <= head.meas;
						acc_sat_q <= head.acc_sat;
						num_q     <= {mag_acc(head.sum_x), {FRAC_BITS{1'b0}}};
						neg_q     <= head.sum_x[ACC_W-1];
						rem_q     <= '0;
						quo_q     <= '0;
						ovf_q     <= 1'b0;
						cnt_q     <= '0;
						axis_q    <= 1'b0;
						if (head.meas == '0) begin
							gx_q    <= '0;
							gy_q    <= '0;
							st_q    <= ST_ZERO_MEAS;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(NUM_W-1)) begin
						if (!axis_q) begin
							// x done, start y on the same divider
							gx_q    <= qres;
							sat_x_q <= ax_sat;
							axis_q  <= 1'b1;
							num_q   <= {mag_acc(sum_y_q), {FRAC_BITS{1'b0}}};
							neg_q   <= sum_y_q[ACC_W-1];
							rem_q   <= '0;
							quo_q   <= '0;
							ovf_q   <= 1'b0;
							cnt_q   <= '0;
						end else begin
							gy_q    <= qres;
							st_q    <= (sat_x_q || ax_sat || acc_sat_q) ? ST_SAT : ST_OK;
							state_q <= S_DONE;
						end
					end else begin
						num_q <= {num_q[NUM_W-2:0], 1'b0};
						rem_q <= rem_n[VALUE_WIDTH-1:0];
						quo_q <= quo_n;
						ovf_q <= ovf_n;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign grad_x    = res_x_q;
	assign grad_y    = res_y_q;
	assign status    = res_st_q;

	a_zero_meas_grad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO_MEAS) |-> (grad_x == '0) && (grad_y == '0))
		else $error("zero-measure result carries a nonzero gradient");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= CNT_W'(NUM_W-1)))
		else $error("divider step count out of range");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done state");

endmodule

/* hdl/green_gauss_cell_gradient_top.sv */
// Green-Gauss cell gradient, 2D, signed Q16.16.
//
// Input channel (in_valid / in_stall): one face per transaction. Faces of a
// cell arrive back to back; last_face closes the cell and carries the cell
// measure. A face can be taken every cycle while the cell queue has room.
// Output channel (out_valid / out_stall): one transaction per cell with
// grad_x, grad_y and status (0 ok, 1 zero measure, 2 saturated).
//
// A last face passes the front stages (products, then clamped terms) and is
// pushed into the cell queue from the last of them; the divider pops it once
// idle. The divider is bit-serial, x then y, and a zero measure skips
// division. Sustained rate is one face per cycle while the cell queue has
// room; the back end takes a new cell only once it has finished the last one.
// The two-entry cell queue lets the accumulator run ahead by up to two
// finished cells.
//
// Reset clears the accumulator, the queue and the divider; no result is
// pending afterwards. When out_stall holds, the result register keeps its
// value; the divider finishes the next cell and then waits, the queue
// fills, and in_stall rises once a further last face finds no room.
module green_gauss_cell_gradient_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] face_value,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] area_x,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] area_y,
	input  logic                                  is_owner,
	input  logic [ggcg_pkg::VALUE_WIDTH-1:0]      cell_measure,
	input  logic                                  last_face,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ggcg_pkg::VALUE_WIDTH-1:0] grad_x,
	output logic signed [ggcg_pkg::VALUE_WIDTH-1:0] grad_y,
	output logic [ggcg_pkg::STATUS_W-1:0]         status
);
	import ggcg_pkg::*;

	logic      push, q_full, pop, q_empty;
	cell_acc_t push_data, head;

	// Face accumulation
	ggcg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.face_value   (face_value),
		.area_x       (area_x),
		.area_y       (area_y),
		.is_owner     (is_owner),
		.cell_measure (cell_measure),
		.last_face    (last_face),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	// Finished cells waiting for the divider
	ggcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	// Division and result register
	ggcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.head      (head),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.grad_x    (grad_x),
		.grad_y    (grad_y),
		.status    (status)
	);

endmodule

/* bench/gradient_monitor.sv */
`timescale 1ns / 1ps
module gradient_monitor (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] face_value,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] area_x,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] area_y,
	input  logic                                    is_owner,
	input  logic [ggcg_pkg::VALUE_WIDTH-1:0]        cell_measure,
	input  logic                                    last_face,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] grad_x,
	input  logic signed [ggcg_pkg::VALUE_WIDTH-1:0] grad_y,
	input  logic [ggcg_pkg::STATUS_W-1:0]           status,
	output int                                      errors,
	output int                                      pending
);
	import ggcg_pkg::*;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] gx;
		logic [VALUE_WIDTH-1:0] gy;
		logic [STATUS_W-1:0]    st;
	} gradient_t;

	// Predicted per-cell state
	logic [ACC_W-1:0] flux_x, flux_y;
	bit               cell_sat;
	bit               quot_sat;
	gradient_t        expected_grads[$];

	logic [ACC_W-1:0] v_ext, ax_ext, ay_ext;
	gradient_t        grad_exp;

	function automatic logic [ACC_W-1:0] widen(logic [VALUE_WIDTH-1:0] x);
		return {{(ACC_W-VALUE_WIDTH){x[VALUE_WIDTH-1]}}, x};
	endfunction

	function automatic logic [ACC_W-1:0] magnitude(logic [ACC_W-1:0] x);
		return x[ACC_W-1] ? -x : x;
	endfunction

	// value * area, magnitude truncated by FRAC_BITS, signed and clamped to 64 bits
	function automatic logic [ACC_W-1:0] flux_term(logic [ACC_W-1:0] v, logic [ACC_W-1:0] a,
		bit neg);
		logic [2*ACC_W-1:0] prod;
		logic [ACC_W-1:0]   lim;
		logic [ACC_W-1:0]   m;
		prod = ({{ACC_W{1'b0}}, magnitude(v)} * {{ACC_W{1'b0}}, magnitude(a)}) >> FRAC_BITS;
		lim = neg ? ACC_MIN : ACC_MAX;
		m = prod[ACC_W-1:0];
		if (prod[2*ACC_W-1:ACC_W] != '0 || m > lim) begin
			m = lim;
			cell_sat = 1'b1;
		end
		return neg ? -m : m;
	endfunction

	function automatic logic [ACC_W-1:0] add_sat(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] r;
		r = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && r[ACC_W-1] != a[ACC_W-1]) begin
			cell_sat = 1'b1;
			r = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
		return r;
	endfunction

	// (sum << FRAC_BITS) / measure, truncated toward zero, clamped to VALUE_WIDTH
	function automatic logic [VALUE_WIDTH-1:0] scaled_quotient(logic [ACC_W-1:0] sum,
		logic [VALUE_WIDTH-1:0] meas);
		logic [2*ACC_W-1:0] num;
		logic [2*ACC_W-1:0] q;
		logic [2*ACC_W-1:0] lim;
		num = {{ACC_W{1'b0}}, magnitude(sum)} << FRAC_BITS;
		q = num / {{(2*ACC_W-VALUE_WIDTH){1'b0}}, meas};
		lim = '0;
		lim[VALUE_WIDTH-1] = 1'b1;
		if (!sum[ACC_W-1])
			lim = lim - 1;
		if (q > lim) begin
			q = lim;
			quot_sat = 1'b1;
		end
		return sum[ACC_W-1] ? -q[VALUE_WIDTH-1:0] : q[VALUE_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flux_x = '0;
			flux_y = '0;
			cell_sat = 1'b0;
			expected_grads.delete();
			errors = 0;
		end else begin
			// Result transaction: compare against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_grads.size() == 0) begin
					$display("%0t: result with none expected: grad_x %0d grad_y %0d status %0d",
						$time, grad_x, grad_y, status);
					errors++;
				end else begin
					grad_exp = expected_grads.pop_front();
					if (grad_x !== grad_exp.gx) begin
						$display("%0t: grad_x expected %0d, actual %0d", $time,
							$signed(grad_exp.gx), grad_x);
						errors++;
					end
					if (grad_y !== grad_exp.gy) begin
						$display("%0t: grad_y expected %0d, actual %0d", $time,
							$signed(grad_exp.gy), grad_y);
						errors++;
					end
					if (status !== grad_exp.st) begin
						$display("%0t: status expected %0d, actual %0d", $time,
							grad_exp.st, status);
						errors++;
					end
				end
			end

			// Face transaction: accumulate, close the cell on the last face
			if (in_valid && !in_stall) begin
				v_ext = widen(face_value);
				ax_ext = widen(area_x);
				ay_ext = widen(area_y);
				flux_x = add_sat(flux_x,
					flux_term(v_ext, ax_ext, v_ext[ACC_W-1] ^ ax_ext[ACC_W-1] ^ !is_owner));
				flux_y = add_sat(flux_y,
					flux_term(v_ext, ay_ext, v_ext[ACC_W-1] ^ ay_ext[ACC_W-1] ^ !is_owner));
				if (last_face) begin
					if (cell_measure == '0) begin
						grad_exp.gx = '0;
						grad_exp.gy = '0;
						grad_exp.st = ST_ZERO_MEAS;
					end else begin
						quot_sat = 1'b0;
						grad_exp.gx = scaled_quotient(flux_x, cell_measure);
						grad_exp.gy = scaled_quotient(flux_y, cell_measure);
						grad_exp.st = (quot_sat || cell_sat) ? ST_SAT : ST_OK;
					end
					expected_grads.push_back(grad_exp);
					flux_x = '0;
					flux_y = '0;
					cell_sat = 1'b0;
				end
			end
		end
		pending = expected_grads.size();
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import ggcg_pkg::*;

	localparam int IDLE_PCT    = 37;
	localparam int FACE_TOTAL  = 1050;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 200;
	localparam logic [VALUE_WIDTH-1:0] ONE  = 1 << FRAC_BITS;
	localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_WIDTH-1:0] face_value = '0;
	logic signed [VALUE_WIDTH-1:0] area_x = '0;
	logic signed [VALUE_WIDTH-1:0] area_y = '0;
	logic is_owner = 1'b0;
	logic [VALUE_WIDTH-1:0] cell_measure = '0;
	logic last_face = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VALUE_WIDTH-1:0] grad_x;
	logic signed [VALUE_WIDTH-1:0] grad_y;
	logic [STATUS_W-1:0] status;
	int errors;
	int pending;

	int faces_sent = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	green_gauss_cell_gradient_top dut (.*);
	gradient_monitor u_grad_mon (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls at random, except during the calm stretch
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Watchdog: too long with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// One face transaction, with random idle cycles ahead of it
	task automatic send_face(logic [VALUE_WIDTH-1:0] v, logic [VALUE_WIDTH-1:0] ax,
		logic [VALUE_WIDTH-1:0] ay, bit owner, logic [VALUE_WIDTH-1:0] meas, bit last);
		calm = (faces_sent >= 400 && faces_sent < 600);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		face_value <= v;
		area_x <= ax;
		area_y <= ay;
		is_owner <= owner;
		cell_measure <= meas;
		last_face <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		faces_sent++;
	endtask

	// Face scalar or area component: mostly moderate, some full range and extremes
	function automatic logic [VALUE_WIDTH-1:0] pick_fixed();
		int unsigned sel;
		sel = $urandom_range(7);
		if (sel < 2)
			return $urandom;
		if (sel == 2) begin
			case ($urandom_range(4))
				0: return VMIN;
				1: return VMAX;
				2: return '0;
				3: return 1;
				default: return '1;
			endcase
		end
		return $urandom_range(2097152) - 1048576;
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_measure();
		int unsigned sel;
		sel = $urandom_range(19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return 1;
		if (sel == 2)
			return '1;
		if (sel < 9)
			return $urandom;
		if (sel < 14)
			return $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
		return $urandom_range(1 << 20, 1);
	endfunction

	initial begin
		int n_faces;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unit cell, sign handling, zero measure, saturation, extremes
		send_face(ONE, ONE, -ONE, 1'b1, ONE, 1'b1);
		send_face(2 * ONE, ONE, '0, 1'b1, $urandom, 1'b0);
		send_face(ONE, '0, ONE, 1'b0, $urandom, 1'b0);
		send_face(ONE, ONE, ONE, 1'b0, 2 * ONE, 1'b1);
		send_face(ONE, ONE, ONE, 1'b1, '0, 1'b1);
		send_face(VMIN, VMIN, VMAX, 1'b1, 1, 1'b1);
		send_face(VMIN, VMIN, VMIN, 1'b0, '0, 1'b1);
		send_face(VMAX, VMAX, VMIN, 1'b0, '1, 1'b1);
		// truncation toward zero, both in the face term and the quotient
		send_face('1, 32'h0001_8000, 32'h0000_8000, 1'b1, 3, 1'b1);
		send_face('0, '0, '0, 1'b0, ONE, 1'b1);
		send_face(-ONE, ONE, VMAX, 1'b0, 32'h8000_0000, 1'b1);
		for (int i = 0; i < 6; i++)
			send_face(32'h0000_FFFF << i, -(ONE << i), ONE >> i, i[0], $urandom, i == 5);
		send_face(1, 1, '1, 1'b1, 1, 1'b1);

		// Random cells, mostly short, now and then long
		while (faces_sent < FACE_TOTAL) begin
			n_faces = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
			for (int i = 0; i < n_faces; i++)
				send_face(pick_fixed(), pick_fixed(), pick_fixed(), $urandom_range(1),
					(i == n_faces - 1) ? pick_measure() : $urandom, i == n_faces - 1);
		end
		in_valid <= 1'b0;

		// Drain outstanding cells, then watch for stray results
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* green_gauss_cell_gradient_top.f */
hdl/ggcg_pkg.sv
hdl/ggcg_front.sv
hdl/ggcg_queue.sv
hdl/ggcg_back.sv
hdl/green_gauss_cell_gradient_top.sv
bench/gradient_monitor.sv
bench/testbench.sv
